// ----- design/def_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// def_pkg
// Shared types, constants and helpers for the directional emboss filter:
// pixel formats, register indexes, weight table, result word and gray
// conversion.
// ----------------------------------------------------------------------------
package def_pkg;

  typedef logic [7:0] gray_t;
  typedef logic [9:0] weight_t;
  typedef logic [4:0] weight_sel_t;

  typedef enum logic [1:0] {
    FMT_RGB_TRUNC = 2'd0,
    FMT_RGB_ROUND = 2'd1,
    FMT_GRAY      = 2'd2,
    FMT_GRAY4     = 2'd3
  } pix_fmt_e;

  typedef enum logic {
    REQ_PIXEL = 1'b0,
    REQ_DRAIN = 1'b1
  } req_type_e;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_LIGHT_ANGLE  = 2'd1,
    REG_PIXEL_FORMAT = 2'd2
  } reg_index_e;

  localparam logic [10:0] IMAGE_WIDTH_RST = 11'd640;
  localparam logic [7:0]  LIGHT_ANGLE_RST = 8'd45;
  localparam logic [7:0]  ANGLE_MAX       = 8'd90;
  localparam int unsigned ANGLE_STEP      = 5;
  localparam int unsigned ANGLE_BIAS      = 3;
  localparam gray_t       MID_GRAY        = 8'h80;
  localparam gray_t       MAX_GRAY        = 8'hff;
  localparam int unsigned RES_FIFO_DEPTH  = 8;

  typedef struct packed {
    weight_t w_right;
    weight_t w_below;
    weight_t w_diag;
  } weight_set_t;

  localparam int unsigned WEIGHT_ENTRIES = 19;

  localparam weight_set_t WEIGHT_TAB [WEIGHT_ENTRIES] = '{
    '{10'd512, 10'd0,   10'd0  }, '{10'd486, 10'd0,   10'd26 },
    '{10'd451, 10'd1,   10'd60 }, '{10'd408, 10'd4,   10'd100},
    '{10'd357, 10'd10,  10'd145}, '{10'd301, 10'd19,  10'd192},
    '{10'd241, 10'd30,  10'd241}, '{10'd180, 10'd45,  10'd287},
    '{10'd128, 10'd64,  10'd320}, '{10'd88,  10'd88,  10'd336},
    '{10'd64,  10'd128, 10'd320}, '{10'd45,  10'd180, 10'd287},
    '{10'd30,  10'd241, 10'd241}, '{10'd19,  10'd301, 10'd192},
    '{10'd10,  10'd357, 10'd145}, '{10'd4,   10'd408, 10'd100},
    '{10'd1,   10'd451, 10'd60 }, '{10'd0,   10'd486, 10'd26 },
    '{10'd0,   10'd512, 10'd0  }
  };

  typedef struct packed {
    gray_t embossed;
    logic  row_end;
    logic  image_end;
  } result_t;

  // gray level of one pixel in the selected format
  function automatic gray_t to_gray(pix_fmt_e fmt, gray_t r, gray_t g, gray_t b);
    logic [16:0] sum_trunc;
    logic [18:0] sum_round;
    gray_t       gray;
    sum_trunc = 17'd153 * 17'(r) + 17'd301 * 17'(g) + 17'd58 * 17'(b);
    sum_round = 19'd306 * 19'(r) + 19'd601 * 19'(g) + 19'd117 * 19'(b) + 19'd512;
    case (fmt)
      FMT_RGB_TRUNC: gray = sum_trunc[16:9];
      FMT_RGB_ROUND: gray = sum_round[17:10];
      FMT_GRAY:      gray = r;
      FMT_GRAY4:     gray = {r[3:0], r[3:0]};
      default:       gray = r;
    endcase
    return gray;
  endfunction

  // (angle + 3) / 5 as a threshold count, angle clamped to 90
  function automatic weight_sel_t angle_sel(logic [7:0] angle);
    logic [7:0]  a;
    weight_sel_t sel;
    a   = (angle > ANGLE_MAX) ? ANGLE_MAX : angle;
    sel = '0;
    for (int k = 1; k < WEIGHT_ENTRIES; k++) begin
      if (a >= 8'(ANGLE_STEP * k - ANGLE_BIAS)) begin
        sel = weight_sel_t'(k);
      end
    end
    return sel;
  endfunction

endpackage
`default_nettype wire

// ----- design/def_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// def_ram
// Simple dual-port RAM, one write port and one read port with registered
// read data.
// ----------------------------------------------------------------------------
module def_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ----- design/def_result_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// def_result_fifo
// Result queue in front of the output port; takes up to two words per
// cycle, hands out one.
// ----------------------------------------------------------------------------
module def_result_fifo #(
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       wr0_valid_i,
  input  wire def_pkg::result_t           wr0_data_i,
  input  wire logic                       wr1_valid_i,
  input  wire def_pkg::result_t           wr1_data_i,
  output logic                            rd_valid_o,
  output def_pkg::result_t                rd_data_o,
  input  wire logic                       rd_ready_i,
  output logic [$clog2(DEPTH+1)-1:0]      count_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  def_pkg::result_t   mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               pop;

  function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign rd_valid_o = (count_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign count_o    = count_q;
  assign pop        = rd_valid_o && rd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    if (wr1_valid_i) begin
      wr_ptr_d = ptr_inc(ptr_inc(wr_ptr_q));
    end else if (wr0_valid_i) begin
      wr_ptr_d = ptr_inc(wr_ptr_q);
    end
    rd_ptr_d = pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + CNT_W'(wr0_valid_i) + CNT_W'(wr1_valid_i) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr0_valid_i) begin
      mem_q[wr_ptr_q] <= wr0_data_i;
    end
    if (wr1_valid_i) begin
      mem_q[ptr_inc(wr_ptr_q)] <= wr1_data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("result fifo overflow");

  a_second_needs_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr1_valid_i |-> wr0_valid_i)
    else $error("second result word without first");

  a_pop_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !wr0_valid_i) |=> count_q == CNT_W'($past(count_q) - 1'b1))
    else $error("result fifo count lost a pop");

endmodule
`default_nettype wire

// ----- design/directional_emboss_filter_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// directional_emboss_filter_unit
// Directional 2x2 emboss over a raster pixel stream with a one-line store.
// ----------------------------------------------------------------------------
// The block takes one item per clock while in_ready_o is high. Each pixel is
// turned into 8-bit gray (format from pixel_format), and the output for pixel
// (r,c) is formed when pixel (r+1,c+1) arrives: 128 + g(r,c) minus the
// angle-weighted sum of the right, below and below-right neighbors, clamped
// to 0..255. Outputs lag one row; the last column of each row is 128, and
// drain items emit the last row as 128s, raising image_end on the final one.
// An accepted item passes an input stage (line store read), a gray stage (line
// store write) and an emboss stage that writes its results into an 8-entry
// result queue in front of the output port. A last-column pixel gives two
// results, first-column pixels none, so a full row still averages one result
// per pixel. in_ready_o drops only when the queue plus the items in flight
// could not hold two more results, i.e. when the output side stalls or
// results come faster than one per cycle. The line store is a MAX_WIDTH x 8
// RAM with no clearing pass after reset; configuration is to be written over
// the APB port only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module directional_emboss_filter_unit #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // pixel input
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        req_type_i,
  input  wire logic [7:0]  red_i,
  input  wire logic [7:0]  green_i,
  input  wire logic [7:0]  blue_i,
  // result output
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic      [7:0]  embossed_o,
  output logic             row_end_o,
  output logic             image_end_o
);

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned WID_W = (COL_W + 1 > 11) ? COL_W + 1 : 11;
  localparam int unsigned DEPTH = def_pkg::RES_FIFO_DEPTH;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned RSV_W = CNT_W + 2;

  typedef struct packed {
    logic             is_pixel;
    logic [COL_W-1:0] col;
    logic             last;
    logic             emit_main;   // neighbor output for the column to the left
    logic             emit_fill;   // fill value 128 after it or alone
    def_pkg::gray_t   red;
    def_pkg::gray_t   green;
    def_pkg::gray_t   blue;
  } in_stage_t;

  typedef struct packed {
    logic             is_pixel;
    logic             last;
    logic             emit_main;
    logic             emit_fill;
    def_pkg::gray_t   above;       // right neighbor of the output pixel
    def_pkg::gray_t   left_cur;    // below neighbor
    def_pkg::gray_t   cur;         // below-right neighbor
    def_pkg::gray_t   left_above;  // the output pixel itself
  } emb_stage_t;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [10:0]       image_width_q;
  logic [7:0]        light_angle_q;
  def_pkg::pix_fmt_e pixel_format_q;
  logic              cfg_we;
  logic [1:0]        cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= def_pkg::IMAGE_WIDTH_RST;
      light_angle_q  <= def_pkg::LIGHT_ANGLE_RST;
      pixel_format_q <= def_pkg::FMT_RGB_TRUNC;
    end else if (cfg_we) begin
      case (cfg_idx)
        def_pkg::REG_IMAGE_WIDTH:  image_width_q  <= pwdata[10:0];
        def_pkg::REG_LIGHT_ANGLE:  light_angle_q  <= pwdata[7:0];
        def_pkg::REG_PIXEL_FORMAT: pixel_format_q <= def_pkg::pix_fmt_e'(pwdata[1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      def_pkg::REG_IMAGE_WIDTH:  prdata = 32'(image_width_q);
      def_pkg::REG_LIGHT_ANGLE:  prdata = 32'(light_angle_q);
      def_pkg::REG_PIXEL_FORMAT: prdata = 32'(pixel_format_q);
      default:                   prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // column tracking at acceptance
  // --------------------------------------------------------------------------
  logic [WID_W-1:0] width_ext;
  logic [COL_W-1:0] last_col, col_clamp, col_q;
  logic             past_q, at_last, is_pixel, in_fire;

  // width 0 acts as 1, above MAX_WIDTH acts as MAX_WIDTH
  assign width_ext = WID_W'(image_width_q);
  always_comb begin
    if (width_ext == '0) begin
      last_col = '0;
    end else if (width_ext > WID_W'(MAX_WIDTH)) begin
      last_col = COL_W'(MAX_WIDTH - 1);
    end else begin
      last_col = COL_W'(width_ext - 1'b1);
    end
  end

  // a column left beyond a narrowed row is the last column
  assign col_clamp = (col_q > last_col) ? last_col : col_q;
  assign at_last   = (col_clamp == last_col);
  assign is_pixel  = (def_pkg::req_type_e'(req_type_i) == def_pkg::REQ_PIXEL);
  assign in_fire   = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      past_q <= 1'b0;
    end else if (in_fire) begin
      col_q <= at_last ? '0 : col_clamp + 1'b1;
      if (at_last) begin
        // a finished pixel row arms output, a finished drain row ends the image
        past_q <= is_pixel;
      end
    end
  end

  // --------------------------------------------------------------------------
  // input stage: line store read issued at acceptance
  // --------------------------------------------------------------------------
  in_stage_t      s1_q;
  logic           s1_valid_q;
  logic           byp_q;
  def_pkg::gray_t byp_gray_q;
  def_pkg::gray_t s1_gray, ram_rdata, s1_above;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q.is_pixel  <= is_pixel;
      s1_q.col       <= col_clamp;
      s1_q.last      <= at_last;
      s1_q.emit_main <= is_pixel && past_q && (col_clamp != '0);
      s1_q.emit_fill <= is_pixel ? (past_q && at_last) : 1'b1;
      s1_q.red       <= red_i;
      s1_q.green     <= green_i;
      s1_q.blue      <= blue_i;
      // read and pending write hit the same entry only when the row is one wide
      byp_q          <= s1_valid_q && s1_q.is_pixel && (s1_q.col == col_clamp);
      byp_gray_q     <= s1_gray;
    end
  end

  def_ram #(
    .WIDTH (8),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q && s1_q.is_pixel),
    .waddr_i (s1_q.col),
    .wdata_i (s1_gray),
    .re_i    (in_fire),
    .raddr_i (col_clamp),
    .rdata_o (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // gray stage: convert, write back, shift the left neighbors
  // --------------------------------------------------------------------------
  emb_stage_t     s2_q;
  logic           s2_valid_q;
  def_pkg::gray_t left_cur_q, left_above_q;

  assign s1_gray  = def_pkg::to_gray(pixel_format_q, s1_q.red, s1_q.green, s1_q.blue);
  assign s1_above = byp_q ? byp_gray_q : ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q   <= 1'b0;
      left_cur_q   <= '0;
      left_above_q <= '0;
    end else begin
      s2_valid_q <= s1_valid_q;
      if (s1_valid_q && s1_q.is_pixel) begin
        left_cur_q   <= s1_gray;
        left_above_q <= s1_above;
      end else if (s1_valid_q && s1_q.last) begin
        // end of drain: clean state for the next image
        left_cur_q   <= '0;
        left_above_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      s2_q.is_pixel   <= s1_q.is_pixel;
      s2_q.last       <= s1_q.last;
      s2_q.emit_main  <= s1_q.emit_main;
      s2_q.emit_fill  <= s1_q.emit_fill;
      s2_q.above      <= s1_above;
      s2_q.left_cur   <= left_cur_q;
      s2_q.cur        <= s1_gray;
      s2_q.left_above <= left_above_q;
    end
  end

  // --------------------------------------------------------------------------
  // emboss stage: weighted sum, clamp, results into the queue
  // --------------------------------------------------------------------------
  def_pkg::weight_set_t weights;
  logic [16:0]          wsum;
  def_pkg::gray_t       shade, emb_value;
  logic signed [9:0]    level;
  def_pkg::result_t     main_res, fill_res, wr0_data;
  logic                 wr0_valid, wr1_valid;
  logic [CNT_W-1:0]     fifo_count;
  def_pkg::result_t     out_res;
  logic [RSV_W-1:0]     reserve;

  assign weights = def_pkg::WEIGHT_TAB[def_pkg::angle_sel(light_angle_q)];

  // each weight row sums to 512, so the scaled sum stays within 8 bits
  assign wsum  = 17'(weights.w_right) * 17'(s2_q.above)
               + 17'(weights.w_below) * 17'(s2_q.left_cur)
               + 17'(weights.w_diag)  * 17'(s2_q.cur);
  assign shade = wsum[16:9];
  assign level = $signed({2'b00, def_pkg::MID_GRAY}) + $signed({2'b00, s2_q.left_above})
               - $signed({2'b00, shade});

  always_comb begin
    if (level[9]) begin
      emb_value = '0;
    end else if (level[8]) begin
      emb_value = def_pkg::MAX_GRAY;
    end else begin
      emb_value = level[7:0];
    end
  end

  assign main_res = '{embossed: emb_value, row_end: 1'b0, image_end: 1'b0};
  assign fill_res = '{embossed:  def_pkg::MID_GRAY,
                      row_end:   s2_q.last,
                      image_end: !s2_q.is_pixel && s2_q.last};

  assign wr0_valid = s2_valid_q && (s2_q.emit_main || s2_q.emit_fill);
  assign wr0_data  = s2_q.emit_main ? main_res : fill_res;
  assign wr1_valid = s2_valid_q && s2_q.emit_main && s2_q.emit_fill;

  def_result_fifo #(
    .DEPTH (DEPTH)
  ) u_result_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr0_valid_i (wr0_valid),
    .wr0_data_i  (wr0_data),
    .wr1_valid_i (wr1_valid),
    .wr1_data_i  (fill_res),
    .rd_valid_o  (out_valid_o),
    .rd_data_o   (out_res),
    .rd_ready_i  (out_ready_i),
    .count_o     (fifo_count)
  );

  assign embossed_o  = out_res.embossed;
  assign row_end_o   = out_res.row_end;
  assign image_end_o = out_res.image_end;

  // every item in flight may still put two words into the queue
  assign reserve    = RSV_W'(fifo_count) + RSV_W'({s1_valid_q, 1'b0})
                    + RSV_W'({s2_valid_q, 1'b0}) + RSV_W'(2);
  assign in_ready_o = (reserve <= RSV_W'(DEPTH));

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
  a_queue_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (RSV_W'(fifo_count) + RSV_W'({s1_valid_q, 1'b0}) + RSV_W'({s2_valid_q, 1'b0}))
      <= RSV_W'(DEPTH))
    else $error("result queue credit exceeded");

  a_image_end_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && image_end_o) |-> row_end_o)
    else $error("image end without row end");

  a_drain_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !is_pixel && at_last) |=> (col_q == '0) && !past_q)
    else $error("final drain item did not restart the image");

endmodule
`default_nettype wire
